[hw/rtl/bfs_pkg.sv]
// Package for the backlight fade and screensaver unit.
// Holds the operation and register index codes, the transaction structs and the constants.
// No dependencies.
`default_nettype none

package bfs_pkg;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_SET        = 3'd1,
      OP_SET_SMOOTH = 3'd2,
      OP_ON         = 3'd3,
      OP_OFF        = 3'd4,
      OP_TOGGLE     = 3'd5,
      OP_TOUCH      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      CSR_BRIGHTNESS    = 2'd0,
      CSR_SAVER_SECONDS = 2'd1,
      CSR_INVERT_PWM    = 2'd2
   } csr_index_type;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned SaverMsWidth  = 26;

   localparam logic [7:0] LevelMax  = 8'd255;
   localparam logic [7:0] ResetStep = 8'd4;
   localparam logic [7:0] WakeStep  = 8'd5;
   localparam logic [7:0] SaverStep = 8'd2;
   localparam logic [9:0] MsPerSecond = 10'd1000;

   typedef struct packed {
      op_type      operation;
      logic [15:0] level;
      logic [7:0]  fade_step;
      logic [31:0] now_ms;
      logic        touch_panel_on;
   } req_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic [7:0] current_level;
      logic [7:0] target_level;
      logic       red_led;
      logic       was_off;
      logic       is_on;
   } rsp_type;

   typedef struct packed {
      logic [7:0]              brightness;
      logic [SaverMsWidth-1:0] saver_ms;
      logic                    invert_pwm;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/bfs_csr.sv]
// Configuration registers of the backlight fade and screensaver unit.
// Depends on bfs_pkg; the idle limit is kept in milliseconds.
`default_nettype none

module bfs_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bfs_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [bfs_pkg::CsrDataWidth-1:0]    csr_wr_data,
   output bfs_pkg::cfg_type                         cfg
);

   logic [7:0]                       brightness_ff;
   logic [bfs_pkg::SaverMsWidth-1:0] saver_ms_ff;
   logic                             invert_ff;
   logic [bfs_pkg::SaverMsWidth-1:0] saver_ms_in;

   // Seconds times one thousand, so the tick compares milliseconds directly.
   assign saver_ms_in = bfs_pkg::SaverMsWidth'(csr_wr_data)
                      * bfs_pkg::SaverMsWidth'(bfs_pkg::MsPerSecond);

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= bfs_pkg::LevelMax;
         saver_ms_ff   <= '0;
         invert_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (bfs_pkg::csr_index_type'(csr_index))
            bfs_pkg::CSR_BRIGHTNESS:    brightness_ff <= csr_wr_data[7:0];
            bfs_pkg::CSR_SAVER_SECONDS: saver_ms_ff   <= saver_ms_in;
            bfs_pkg::CSR_INVERT_PWM:    invert_ff     <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.brightness = brightness_ff;
   assign cfg.saver_ms   = saver_ms_ff;
   assign cfg.invert_pwm = invert_ff;

endmodule

`default_nettype wire

[hw/rtl/bfs_core.sv]
// Level state and single-pass update logic of the backlight fade and screensaver unit.
// Depends on bfs_pkg; produces the result of the accepted transaction combinationally.
`default_nettype none

module bfs_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire bfs_pkg::req_type  req,
   input  wire bfs_pkg::cfg_type  cfg,
   output bfs_pkg::rsp_type       rsp
);

   logic [7:0]  power_ff, power_in;
   logic [7:0]  goal_ff, goal_in;
   logic [7:0]  step_ff, step_in;
   logic [31:0] last_touch_ff, last_touch_in;
   logic        led_ff, led_in;
   logic        was_off;

   logic [7:0]  req_level;
   logic [31:0] idle_ms;
   logic        saver_hit;
   logic [7:0]  goal_tick;
   logic [7:0]  step_tick;
   logic [8:0]  up_sum;
   logic [8:0]  down_limit;
   logic [7:0]  faded;

   assign req_level = (req.level[15:8] != 8'd0) ? bfs_pkg::LevelMax : req.level[7:0];

   // Screensaver check happens before the fade of the same tick.
   assign idle_ms   = req.now_ms - last_touch_ff;
   assign saver_hit = (cfg.saver_ms != '0) && (power_ff != 8'd0) && (goal_ff != 8'd0)
                    && req.touch_panel_on
                    && (idle_ms >= 32'(cfg.saver_ms));
   assign goal_tick = saver_hit ? 8'd0 : goal_ff;
   assign step_tick = saver_hit ? bfs_pkg::SaverStep : step_ff;

   // Move toward the target by one step, never overshooting it.
   assign up_sum     = {1'b0, power_ff} + {1'b0, step_tick};
   assign down_limit = {1'b0, goal_tick} + {1'b0, step_tick};

   always_comb begin
      if (power_ff < goal_tick) begin
         faded = (up_sum > {1'b0, goal_tick}) ? goal_tick : up_sum[7:0];
      end else if (power_ff > goal_tick) begin
         faded = ({1'b0, power_ff} >= down_limit) ? (power_ff - step_tick) : goal_tick;
      end else begin
         faded = power_ff;
      end
   end

   always_comb begin
      power_in      = power_ff;
      goal_in       = goal_ff;
      step_in       = step_ff;
      last_touch_in = last_touch_ff;
      led_in        = led_ff;
      was_off       = 1'b0;
      case (req.operation)
         bfs_pkg::OP_TICK: begin
            goal_in  = goal_tick;
            step_in  = step_tick;
            power_in = faded;
            if (faded == 8'd0) begin
               led_in = 1'b1;
            end
         end
         bfs_pkg::OP_SET: begin
            power_in = req_level;
            goal_in  = req_level;
         end
         bfs_pkg::OP_SET_SMOOTH: begin
            goal_in = req_level;
            step_in = req.fade_step;
         end
         bfs_pkg::OP_ON: begin
            power_in = cfg.brightness;
            goal_in  = cfg.brightness;
            led_in   = 1'b0;
         end
         bfs_pkg::OP_OFF: begin
            power_in = 8'd0;
            goal_in  = 8'd0;
            led_in   = 1'b1;
         end
         bfs_pkg::OP_TOGGLE: begin
            if (power_ff != 8'd0) begin
               power_in = 8'd0;
               goal_in  = 8'd0;
               led_in   = 1'b1;
            end else begin
               power_in = cfg.brightness;
               goal_in  = cfg.brightness;
               led_in   = 1'b0;
            end
         end
         bfs_pkg::OP_TOUCH: begin
            was_off       = (power_ff == 8'd0);
            last_touch_in = req.now_ms;
            if ((power_ff == 8'd0) || (power_ff != goal_ff)) begin
               led_in  = 1'b0;
               goal_in = cfg.brightness;
               step_in = bfs_pkg::WakeStep;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff      <= 8'd0;
         goal_ff       <= bfs_pkg::LevelMax;
         step_ff       <= bfs_pkg::ResetStep;
         last_touch_ff <= 32'd0;
         led_ff        <= 1'b0;
      end else if (accept) begin
         power_ff      <= power_in;
         goal_ff       <= goal_in;
         step_ff       <= step_in;
         last_touch_ff <= last_touch_in;
         led_ff        <= led_in;
      end
   end

   assign rsp.pwm_duty      = cfg.invert_pwm ? (bfs_pkg::LevelMax - power_in) : power_in;
   assign rsp.current_level = power_in;
   assign rsp.target_level  = goal_in;
   assign rsp.red_led       = led_in;
   assign rsp.was_off       = was_off;
   assign rsp.is_on         = (power_in != 8'd0);

`ifndef ASSERT_OFF
   a_reset_state: assert property (@(posedge clock)
      reset |=> (power_ff == 8'd0) && (step_ff == bfs_pkg::ResetStep) && !led_ff)
      else $error("state not cleared by reset");

   a_off_state: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.operation == bfs_pkg::OP_OFF))
      |=> (power_ff == 8'd0) && (goal_ff == 8'd0) && led_ff)
      else $error("switch off did not leave the light dark");

   a_touch_time: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.operation == bfs_pkg::OP_TOUCH))
      |=> (last_touch_ff == $past(req.now_ms)))
      else $error("touch did not restart the idle timer");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(power_ff) && $stable(goal_ff) && $stable(step_ff))
      else $error("level state changed without a transaction");
`endif

endmodule

`default_nettype wire

[hw/rtl/bfs_out_buf.sv]
// Two-entry result buffer of the backlight fade and screensaver unit.
// Depends on bfs_pkg; an output register backed by a skid register.
`default_nettype none

module bfs_out_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bfs_pkg::rsp_type  load_data,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output bfs_pkg::rsp_type       rsp_payload
);

   logic             out_valid_ff;
   logic             skid_valid_ff;
   bfs_pkg::rsp_type out_data_ff;
   bfs_pkg::rsp_type skid_data_ff;
   logic             take;

   assign take       = out_valid_ff && rsp_ready;
   assign load_ready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (load) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (!out_valid_ff || take) begin
            out_data_ff <= load_data;
         end else begin
            skid_data_ff <= load_data;
         end
      end else if (take && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

`default_nettype wire

[hw/rtl/backlight_fade_screensaver_unit.sv]
// Top level of the backlight fade and screensaver unit.
// Depends on bfs_pkg, bfs_csr, bfs_core and bfs_out_buf.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  bfs_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  bfs_pkg::rsp_type
//   csr_      in         csr_wr_en              csr_index, csr_wr_data
//
// One transaction is accepted per cycle while the buffer has room; its result
// is registered in the output register, else in the skid register. The whole
// update is one pass through the core logic, whose longest path is the 32-bit
// idle-time subtract and compare feeding the fade. Reset is synchronous; there
// is no clearing pass. A two-entry result buffer keeps requests flowing while
// one result waits; requests stall only when both entries are full.
`default_nettype none

module backlight_fade_screensaver_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire bfs_pkg::req_type                   req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output bfs_pkg::rsp_type                        rsp_payload,
   input  wire logic                               csr_wr_en,
   input  wire logic [bfs_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [bfs_pkg::CsrDataWidth-1:0]   csr_wr_data
);

   bfs_pkg::cfg_type cfg;
   bfs_pkg::rsp_type core_rsp;
   logic             accept;

   // A transaction is taken whenever the result buffer has a free entry.
   assign accept = req_valid && req_ready;

   bfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // The core updates its level state on acceptance and reports the new state.
   bfs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg),
      .rsp    (core_rsp)
   );

   bfs_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_data   (core_rsp),
      .load_ready  (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[tb/backlight_level_checker.sv]
`timescale 1ns / 100ps
// Checker for the backlight fade and screensaver unit: predicts each result and compares it.
// Depends on bfs_pkg for the transaction structs, codes and constants.

module backlight_level_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  bfs_pkg::req_type                  req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  bfs_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [bfs_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [bfs_pkg::CsrDataWidth-1:0]  csr_wr_data,
   output int unsigned                       results_pending,
   output int unsigned                       mismatch_count
);

   // Copy of the block's registers, followed from the write port.
   logic [7:0]  cfg_brightness;
   logic [15:0] cfg_saver_seconds;
   logic        cfg_invert;

   // Copy of the block's state.
   logic [7:0]  lvl_now;
   logic [7:0]  lvl_goal;
   logic [7:0]  fade_size;
   logic [31:0] touch_stamp;
   logic        led_on;

   bfs_pkg::rsp_type expected_levels[$];
   bfs_pkg::rsp_type want;
   int unsigned      waiting = 0;
   int unsigned      mismatches = 0;

   assign results_pending = waiting;
   assign mismatch_count  = mismatches;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      mismatches++;
      $display("%0t backlight check: %s is %0d, predicted %0d", $time, what, got, wanted);
   endtask

   // Applies one request to the state copy and returns the result it should produce.
   function automatic bfs_pkg::rsp_type advance_backlight(input bfs_pkg::req_type item);
      int unsigned      p;
      int unsigned      goal;
      int unsigned      stepv;
      logic [31:0]      elapsed;
      logic [31:0]      idle_s;
      logic [7:0]       req_lvl;
      logic             off_before;
      bfs_pkg::rsp_type r;
      off_before = 1'b0;
      req_lvl = (item.level > 16'd255) ? bfs_pkg::LevelMax : item.level[7:0];
      case (item.operation)
         bfs_pkg::OP_TICK: begin
            if (cfg_saver_seconds != 0 && lvl_now != 0 && lvl_goal != 0
                && item.touch_panel_on) begin
               elapsed = item.now_ms - touch_stamp;
               idle_s  = elapsed / 32'(bfs_pkg::MsPerSecond);
               if (idle_s >= 32'(cfg_saver_seconds)) begin
                  lvl_goal  = 8'd0;
                  fade_size = bfs_pkg::SaverStep;
               end
            end
            p     = lvl_now;
            goal  = lvl_goal;
            stepv = fade_size;
            if (p < goal) begin
               p = p + stepv;
               if (p > goal) p = goal;
            end else if (p > goal) begin
               p = (p >= goal + stepv) ? p - stepv : goal;
            end
            lvl_now = p[7:0];
            if (p == 0) led_on = 1'b1;
         end
         bfs_pkg::OP_SET: begin
            lvl_now  = req_lvl;
            lvl_goal = req_lvl;
         end
         bfs_pkg::OP_SET_SMOOTH: begin
            lvl_goal  = req_lvl;
            fade_size = item.fade_step;
         end
         bfs_pkg::OP_ON: begin
            lvl_now  = cfg_brightness;
            lvl_goal = cfg_brightness;
            led_on   = 1'b0;
         end
         bfs_pkg::OP_OFF: begin
            lvl_now  = 8'd0;
            lvl_goal = 8'd0;
            led_on   = 1'b1;
         end
         bfs_pkg::OP_TOGGLE: begin
            if (lvl_now != 0) begin
               lvl_now  = 8'd0;
               lvl_goal = 8'd0;
               led_on   = 1'b1;
            end else begin
               lvl_now  = cfg_brightness;
               lvl_goal = cfg_brightness;
               led_on   = 1'b0;
            end
         end
         bfs_pkg::OP_TOUCH: begin
            off_before  = (lvl_now == 0);
            touch_stamp = item.now_ms;
            if (off_before || lvl_now != lvl_goal) begin
               led_on    = 1'b0;
               lvl_goal  = cfg_brightness;
               fade_size = bfs_pkg::WakeStep;
            end
         end
         default: begin
         end
      endcase
      r.pwm_duty      = cfg_invert ? bfs_pkg::LevelMax - lvl_now : lvl_now;
      r.current_level = lvl_now;
      r.target_level  = lvl_goal;
      r.red_led       = led_on;
      r.was_off       = off_before;
      r.is_on         = (lvl_now != 0);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_brightness    <= bfs_pkg::LevelMax;
         cfg_saver_seconds <= 16'd0;
         cfg_invert        <= 1'b0;
         lvl_now           <= 8'd0;
         lvl_goal          <= bfs_pkg::LevelMax;
         fade_size         <= bfs_pkg::ResetStep;
         touch_stamp       <= 32'd0;
         led_on            <= 1'b0;
         expected_levels.delete();
      end else begin
         if (csr_wr_en) begin
            case (bfs_pkg::csr_index_type'(csr_index))
               bfs_pkg::CSR_BRIGHTNESS:    cfg_brightness    = csr_wr_data[7:0];
               bfs_pkg::CSR_SAVER_SECONDS: cfg_saver_seconds = csr_wr_data[15:0];
               bfs_pkg::CSR_INVERT_PWM:    cfg_invert        = csr_wr_data[0];
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("result with none outstanding", 32'(rsp_payload), 32'd0);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_payload.pwm_duty !== want.pwm_duty)
                  report_mismatch("pwm_duty", 32'(rsp_payload.pwm_duty), 32'(want.pwm_duty));
               if (rsp_payload.current_level !== want.current_level)
                  report_mismatch("current_level", 32'(rsp_payload.current_level),
                                  32'(want.current_level));
               if (rsp_payload.target_level !== want.target_level)
                  report_mismatch("target_level", 32'(rsp_payload.target_level),
                                  32'(want.target_level));
               if (rsp_payload.red_led !== want.red_led)
                  report_mismatch("red_led", 32'(rsp_payload.red_led), 32'(want.red_led));
               if (rsp_payload.was_off !== want.was_off)
                  report_mismatch("was_off", 32'(rsp_payload.was_off), 32'(want.was_off));
               if (rsp_payload.is_on !== want.is_on)
                  report_mismatch("is_on", 32'(rsp_payload.is_on), 32'(want.is_on));
            end
         end
         if (req_valid && req_ready) begin
            expected_levels.push_back(advance_backlight(req_payload));
         end
      end
      waiting <= expected_levels.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top of the testbench for backlight_fade_screensaver_unit: clock, reset, stimulus and verdict.
// Depends on bfs_pkg, the unit itself and backlight_level_checker.

module testbench;

   // The one operation code the package leaves unnamed; the block must ignore it.
   localparam logic [2:0] OpUnused = 3'd7;
   // Cycles in which no transaction moves on either channel before the run is declared hung.
   localparam int unsigned QuietLimit = 4000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   bfs_pkg::req_type                  req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   bfs_pkg::rsp_type                  rsp_payload;
   logic                              csr_wr_en = 1'b0;
   logic [bfs_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [bfs_pkg::CsrDataWidth-1:0]  csr_wr_data = '0;

   int unsigned results_pending;
   int unsigned mismatch_count;
   int unsigned quiet_cycles = 0;
   logic        timed_out = 1'b0;

   // Chances, in percent, that the sender holds back an item and that the receiver
   // refuses a result in a given cycle.
   int unsigned sender_idle_pct = 6;
   int unsigned receiver_idle_pct = 59;

   // Running millisecond timestamp used by the random transactions.
   logic [31:0] stamp_ms = 32'h0000_03E8;

   always #6 clock = ~clock;

   backlight_fade_screensaver_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   backlight_level_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .results_pending (results_pending),
      .mismatch_count  (mismatch_count)
   );

   // The receiver decides afresh every cycle whether it will take a result.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // The watchdog counts cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic bfs_pkg::req_type request(input bfs_pkg::op_type op,
                                                input logic [15:0] lvl,
                                                input logic [7:0] fstep,
                                                input logic [31:0] ms,
                                                input logic panel);
      bfs_pkg::req_type item;
      item.operation      = op;
      item.level          = lvl;
      item.fade_step      = fstep;
      item.now_ms         = ms;
      item.touch_panel_on = panel;
      return item;
   endfunction

   // Random transactions lean towards ticks and touches, so that fades run their course
   // and the screensaver gets a chance to fire between touches.
   function automatic bfs_pkg::req_type random_request();
      int unsigned      pick;
      bfs_pkg::req_type item;
      pick = $urandom_range(99);
      if (pick < 45)      item.operation = bfs_pkg::OP_TICK;
      else if (pick < 57) item.operation = bfs_pkg::OP_TOUCH;
      else if (pick < 68) item.operation = bfs_pkg::OP_SET_SMOOTH;
      else if (pick < 76) item.operation = bfs_pkg::OP_SET;
      else if (pick < 82) item.operation = bfs_pkg::OP_ON;
      else if (pick < 88) item.operation = bfs_pkg::OP_OFF;
      else if (pick < 98) item.operation = bfs_pkg::OP_TOGGLE;
      else                item.operation = bfs_pkg::op_type'(OpUnused);
      case ($urandom_range(9))
         0:       item.level = 16'd0;
         1:       item.level = 16'd255;
         2:       item.level = 16'($urandom_range(65535));
         default: item.level = 16'($urandom_range(255));
      endcase
      case ($urandom_range(9))
         0:       item.fade_step = 8'd0;
         1:       item.fade_step = 8'($urandom_range(255));
         2:       item.fade_step = 8'd255;
         default: item.fade_step = 8'($urandom_range(1, 12));
      endcase
      // Mostly steady time, with the odd jump anywhere in the 32-bit range.
      case ($urandom_range(19))
         0:       stamp_ms = $urandom;
         1:       stamp_ms = stamp_ms;
         default: stamp_ms = stamp_ms + $urandom_range(50, 1500);
      endcase
      item.now_ms         = stamp_ms;
      item.touch_panel_on = ($urandom_range(9) != 0);
      return item;
   endfunction

   // Presents one transaction, possibly after a few idle cycles, and returns at the edge
   // where it is accepted. Valid is only lowered in a later step, never in the same one.
   task automatic send_request(input bfs_pkg::req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Waits until every predicted result has been taken, then lets the unit settle.
   // The first edge makes sure the checker has counted the last accepted request.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges; unused upper bits carry noise.
   task automatic apply_settings(input logic [7:0] bright, input logic [15:0] secs,
                                 input logic inv);
      csr_wr_en   <= 1'b1;
      csr_index   <= bfs_pkg::CSR_BRIGHTNESS;
      csr_wr_data <= {8'($urandom), bright};
      @(posedge clock);
      csr_index   <= bfs_pkg::CSR_SAVER_SECONDS;
      csr_wr_data <= secs;
      @(posedge clock);
      csr_index   <= bfs_pkg::CSR_INVERT_PWM;
      csr_wr_data <= {15'($urandom), inv};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings: the level starts at zero heading for 255.
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'd0, 1'b1));
      // A requested level above 255 saturates.
      send_request(request(bfs_pkg::OP_SET, 16'hFFFF, 8'd0, 32'd0, 1'b1));
      send_request(request(bfs_pkg::OP_SET, 16'd0, 8'd0, 32'd0, 1'b1));
      // A zero fade step freezes the level, and a tick at level zero lights the red LED.
      send_request(request(bfs_pkg::OP_SET_SMOOTH, 16'd300, 8'd0, 32'd0, 1'b1));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'd10, 1'b1));
      // Full-size steps both ways must be clamped at the target.
      send_request(request(bfs_pkg::OP_SET_SMOOTH, 16'd200, 8'd255, 32'd20, 1'b1));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'd30, 1'b1));
      send_request(request(bfs_pkg::OP_SET_SMOOTH, 16'd10, 8'd255, 32'd40, 1'b1));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'd50, 1'b1));
      send_request(request(bfs_pkg::OP_SET_SMOOTH, 16'd0, 8'd3, 32'd60, 1'b1));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'd70, 1'b1));
      send_request(request(bfs_pkg::OP_ON, 16'd0, 8'd0, 32'd80, 1'b1));
      send_request(request(bfs_pkg::OP_OFF, 16'd0, 8'd0, 32'd90, 1'b1));
      send_request(request(bfs_pkg::OP_TOGGLE, 16'd0, 8'd0, 32'd100, 1'b1));
      send_request(request(bfs_pkg::OP_TOGGLE, 16'd0, 8'd0, 32'd110, 1'b1));
      // Touch while dark wakes the light; touch while still fading wakes it again.
      send_request(request(bfs_pkg::OP_TOUCH, 16'd0, 8'd0, 32'd1000, 1'b1));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'd1010, 1'b1));
      send_request(request(bfs_pkg::OP_TOUCH, 16'd0, 8'd0, 32'd1020, 1'b1));
      // Touch with the level already at its target only restarts the idle timer.
      send_request(request(bfs_pkg::OP_SET, 16'd128, 8'd0, 32'd1030, 1'b1));
      send_request(request(bfs_pkg::OP_TOUCH, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1));
      send_request(request(bfs_pkg::op_type'(OpUnused), 16'd77, 8'd9, 32'd1040, 1'b1));

      // Second directed part: dark brightness, a one-second screensaver and inverted duty.
      wait_drained();
      apply_settings(8'd0, 16'd1, 1'b1);
      send_request(request(bfs_pkg::OP_SET, 16'd100, 8'd0, 32'd0, 1'b1));
      send_request(request(bfs_pkg::OP_TOUCH, 16'd0, 8'd0, 32'hFFFF_FC18, 1'b1));
      // Idle time is measured across the wrap of the timestamp; with the panel off the
      // screensaver must stay quiet, with it on the fade to zero starts on the same tick.
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'h0000_03E8, 1'b0));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'h0000_03E8, 1'b1));
      send_request(request(bfs_pkg::OP_TOUCH, 16'd0, 8'd0, 32'h0000_03F0, 1'b1));
      send_request(request(bfs_pkg::OP_TICK, 16'd0, 8'd0, 32'h0000_0400, 1'b1));

      // Random part in six segments, each with settings of its own. The first two have a
      // slow receiver, the next two a slow sender and the last two run flat out.
      for (int seg = 0; seg < 6; seg++) begin
         wait_drained();
         case (seg)
            0: apply_settings(8'd255, 16'd1, 1'b0);
            1: apply_settings(8'd0, 16'd0, 1'b1);
            2: apply_settings(8'($urandom_range(255)), 16'd2, 1'b1);
            3: apply_settings(8'd1, 16'd65535, 1'b0);
            4: apply_settings(8'($urandom_range(255)), 16'($urandom_range(1, 4)),
                              1'($urandom_range(1)));
            default: apply_settings(8'd200, 16'd3, 1'b0);
         endcase
         if (seg < 2) begin
            sender_idle_pct   = 6;
            receiver_idle_pct = 59;
         end else if (seg < 4) begin
            sender_idle_pct   = 59;
            receiver_idle_pct = 6;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         repeat (105) send_request(random_request());
      end
      wait_drained();
   endtask

   initial begin
      fork
         run_stimulus();
         begin
            while (quiet_cycles < QuietLimit) @(posedge clock);
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && mismatch_count == 0 && results_pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
